// ===== sv/complex_dft_time_series_assert.svh =====
// ----------------------------------------------------------------------------
// complex_dft_time_series assertion macros
// Shared assertion forms for the port checker of the transform block.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_DFT_TIME_SERIES_ASSERT_SVH
`define COMPLEX_DFT_TIME_SERIES_ASSERT_SVH

// Checked only outside of reset.
`define CDFT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cdft port check failed");

// Checked at every edge, reset included.
`define CDFT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("cdft port check failed during reset");

`endif

// ===== sv/cdft_pkg.sv =====
// ----------------------------------------------------------------------------
// cdft_pkg
// Types, widths and twiddle helpers of the direct complex transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdft_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_WAIT
  } cdft_state_e;

  // Datapath widths.
  localparam int SMP_W  = 32;
  localparam int TW_W   = 20;
  localparam int PROD_W = SMP_W + TW_W;
  localparam int ACC_W  = 58;
  localparam int DROP_W = 18;
  localparam int RND_W  = ACC_W - DROP_W;
  localparam int OUT_W  = 38;
  localparam int BIN_W  = 6;

  typedef logic signed [TW_W-1:0] tw_t;

  // Control that travels with a multiply-accumulate beat down the pipe.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } pipe_ctl_t;

  // Rounding and saturation constants.
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(131072);
  localparam logic signed [RND_W-1:0] SAT_HI = 40'sh1F_FFFF_FFFF;
  localparam logic signed [RND_W-1:0] SAT_LO = 40'shE0_0000_0000;
  localparam logic signed [OUT_W-1:0] OUT_HI = 38'sh1F_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_LO = 38'sh20_0000_0000;

  // Angle constants in Q30.
  localparam longint PI_QUARTER_Q30 = 843314857;
  localparam longint ONE_Q30        = 1073741824;

  // Cosine of an angle in the first octant (Q30 in), rounded to Q1.18.
  function automatic tw_t trig_cos(input longint theta);
    longint x2;
    longint term;
    longint c;
    x2   = (theta * theta) >>> 30;
    term = ONE_Q30;
    c    = ONE_Q30;
    term = ((term * x2) >>> 30) / 2;   c = c - term;
    term = ((term * x2) >>> 30) / 12;  c = c + term;
    term = ((term * x2) >>> 30) / 30;  c = c - term;
    term = ((term * x2) >>> 30) / 56;  c = c + term;
    term = ((term * x2) >>> 30) / 90;  c = c - term;
    term = ((term * x2) >>> 30) / 132; c = c + term;
    term = ((term * x2) >>> 30) / 182; c = c - term;
    if (c < 0) begin
      c = 0;
    end
    return TW_W'((c + 2048) >>> 12);
  endfunction

  // Sine of an angle in the first octant (Q30 in), rounded to Q1.18.
  function automatic tw_t trig_sin(input longint theta);
    longint x2;
    longint term;
    longint s;
    x2   = (theta * theta) >>> 30;
    term = theta;
    s    = theta;
    term = ((term * x2) >>> 30) / 6;   s = s - term;
    term = ((term * x2) >>> 30) / 20;  s = s + term;
    term = ((term * x2) >>> 30) / 42;  s = s - term;
    term = ((term * x2) >>> 30) / 72;  s = s + term;
    term = ((term * x2) >>> 30) / 110; s = s - term;
    term = ((term * x2) >>> 30) / 156; s = s + term;
    term = ((term * x2) >>> 30) / 210; s = s - term;
    if (s < 0) begin
      s = 0;
    end
    return TW_W'((s + 2048) >>> 12);
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdft_if.sv =====
// ----------------------------------------------------------------------------
// cdft_if
// Valid/ready channels of the transform block: sample beats in, bin beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdft_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_real;
  logic signed [31:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface cdft_bin_if;
  logic               valid;
  logic               ready;
  logic signed [37:0] spectrum_real;
  logic signed [37:0] spectrum_imag;
  logic        [5:0]  bin_index;
  logic signed [5:0]  signed_momentum;
  logic               last_of_run;

  modport source (output valid, output spectrum_real, output spectrum_imag,
                  output bin_index, output signed_momentum, output last_of_run,
                  input ready);
  modport sink   (input valid, input spectrum_real, input spectrum_imag,
                  input bin_index, input signed_momentum, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/complex_dft_time_series.sv =====
// ----------------------------------------------------------------------------
// complex_dft_time_series
// Direct complex DFT of a loaded series of N samples, one bin per beat out.
// ----------------------------------------------------------------------------
//
//   channel    dir  beat contents                                 rate
//   sample_i   in   sample_real, sample_imag (Q16.16)             1 per cycle while loading
//   bin_o      out  spectrum_real/imag (Q22.16), bin_index,       1 per computed bin
//                   signed_momentum, last_of_run
//
// Loading accepts one sample per cycle. The N-th sample starts the transform,
// which runs one complex multiply-accumulate per cycle while a bin is summed, on a
// single shared MAC: each bin issues N terms, then waits for the last one to drain
// through the pipeline and for the output register before the bin is loaded.
// After reset the block accepts samples at once; the sample memory is not cleared.
// A stalled bin beat holds in the output register; the next bin, once summed, waits.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_dft_time_series #(
  parameter int SERIES_LENGTH = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  cdft_sample_if.sink  sample_i,
  cdft_bin_if.source   bin_o
);

  import cdft_pkg::*;

  localparam int IDX_W = (SERIES_LENGTH > 1) ? $clog2(SERIES_LENGTH) : 1;
  localparam int HALF  = SERIES_LENGTH / 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERIES_LENGTH - 1);
  localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(SERIES_LENGTH);

  // Twiddle table, built at elaboration from octant symmetry.
  tw_t rom_cos [SERIES_LENGTH];
  tw_t rom_sin [SERIES_LENGTH];

  for (genvar gm = 0; gm < SERIES_LENGTH; gm++) begin : g_rom
    localparam int     U     = 8 * gm;
    localparam int     OCT   = U / SERIES_LENGTH;
    localparam int     REM   = U % SERIES_LENGTH;
    localparam int     OCT8  = OCT % 8;
    localparam longint PART  = (OCT % 2 == 1) ? longint'(SERIES_LENGTH - REM) : longint'(REM);
    localparam longint THETA = (PART * PI_QUARTER_Q30 + SERIES_LENGTH / 2) / SERIES_LENGTH;
    localparam tw_t    C0    = trig_cos(THETA);
    localparam tw_t    S0    = trig_sin(THETA);
    localparam tw_t    CO    = (OCT8 == 0 || OCT8 == 7) ? C0 :
                               (OCT8 == 1 || OCT8 == 6) ? S0 :
                               (OCT8 == 2 || OCT8 == 5) ? -S0 : -C0;
    localparam tw_t    SI    = (OCT8 == 0 || OCT8 == 3) ? S0 :
                               (OCT8 == 1 || OCT8 == 2) ? C0 :
                               (OCT8 == 4 || OCT8 == 7) ? -S0 : -C0;
    assign rom_cos[gm] = CO;
    assign rom_sin[gm] = SI;
  end

  // Round half up to the input fraction and clamp to the output range.
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] v;
    logic signed [RND_W-1:0] r;
    v = a + ROUND_HALF;
    r = RND_W'(v >>> DROP_W);
    priority if (r > SAT_HI) begin
      return OUT_HI;
    end else if (r < SAT_LO) begin
      return OUT_LO;
    end else begin
      return OUT_W'(r);
    end
  endfunction

  cdft_state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] t_q, t_d;
  logic [IDX_W-1:0] tw_q, tw_d;
  logic [IDX_W:0]   tw_sum;
  logic             in_fire;
  logic             issue;
  logic             out_load;
  logic             acc_done_q;
  logic             out_valid_q;

  assign in_fire = sample_i.valid && sample_i.ready;
  assign tw_sum  = {1'b0, tw_q} + {1'b0, k_q};

  // Sequencer: next state, counters and strobes.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    t_d      = t_q;
    tw_d     = tw_q;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            k_d     = '0;
            t_d     = '0;
            tw_d    = '0;
            state_d = S_CALC;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_CALC: begin
        issue = 1'b1;
        if (t_q == LAST_IDX) begin
          t_d     = '0;
          tw_d    = '0;
          state_d = S_WAIT;
        end else begin
          t_d  = t_q + 1'b1;
          tw_d = (tw_sum >= N_EXT) ? IDX_W'(tw_sum - N_EXT) : IDX_W'(tw_sum);
        end
      end
      S_WAIT: begin
        if (acc_done_q && (!out_valid_q || bin_o.ready)) begin
          out_load = 1'b1;
          if (k_q == LAST_IDX) begin
            k_d     = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_CALC;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
      t_q     <= '0;
      tw_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      t_q     <= t_d;
      tw_q    <= tw_d;
    end
  end

  assign sample_i.ready = (state_q == S_LOAD);

  // Sample memory: real part in the low half, imaginary in the high half.
  logic [2*SMP_W-1:0] store_q [SERIES_LENGTH];
  logic [2*SMP_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_q[cnt_q] <= {sample_i.sample_imag, sample_i.sample_real};
    end
    rd_q <= store_q[t_q];
  end

  // Stage 1: sample read and twiddle lookup.
  pipe_ctl_t s1_q, s2_q;
  tw_t       cos_q, sin_q;

  always_ff @(posedge clk_i) begin
    cos_q <= rom_cos[tw_q];
    sin_q <= rom_sin[tw_q];
  end

  // Stage 2: four partial products of the complex multiply.
  logic signed [SMP_W-1:0]  rd_re, rd_im;
  logic signed [PROD_W-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;

  assign rd_re = $signed(rd_q[SMP_W-1:0]);
  assign rd_im = $signed(rd_q[2*SMP_W-1:SMP_W]);

  always_ff @(posedge clk_i) begin
    p_rc_q <= rd_re * cos_q;
    p_is_q <= rd_im * sin_q;
    p_ic_q <= rd_im * cos_q;
    p_rs_q <= rd_re * sin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= '{valid: issue, first: (t_q == '0), last: (t_q == LAST_IDX)};
      s2_q <= s1_q;
    end
  end

  // Stage 3: exact accumulation of the bin.
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0] sum_re, sum_im;

  assign sum_re = ACC_W'(p_rc_q) + ACC_W'(p_is_q);
  assign sum_im = ACC_W'(p_ic_q) - ACC_W'(p_rs_q);

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      acc_re_q <= s2_q.first ? sum_re : acc_re_q + sum_re;
      acc_im_q <= s2_q.first ? sum_im : acc_im_q + sum_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_done_q <= 1'b0;
    end else if (out_load) begin
      acc_done_q <= 1'b0;
    end else if (s2_q.valid && s2_q.last) begin
      acc_done_q <= 1'b1;
    end
  end

  // Output register: rounded bin with its index and momentum.
  logic signed [6:0]       k_ext;
  logic signed [OUT_W-1:0] re_q, im_q;
  logic [BIN_W-1:0]        bin_q;
  logic signed [BIN_W-1:0] mom_q;
  logic                    last_q;

  assign k_ext = 7'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (bin_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      re_q   <= round_sat(acc_re_q);
      im_q   <= round_sat(acc_im_q);
      bin_q  <= BIN_W'(k_q);
      mom_q  <= (k_ext >= 7'(HALF)) ? BIN_W'(k_ext - 7'(SERIES_LENGTH)) : BIN_W'(k_ext);
      last_q <= (k_q == LAST_IDX);
    end
  end

  assign bin_o.valid           = out_valid_q;
  assign bin_o.spectrum_real   = re_q;
  assign bin_o.spectrum_imag   = im_q;
  assign bin_o.bin_index       = bin_q;
  assign bin_o.signed_momentum = mom_q;
  assign bin_o.last_of_run     = last_q;

endmodule

`default_nettype wire

// ===== sv/cdft_checker.sv =====
// ----------------------------------------------------------------------------
// cdft_checker
// Port-level checks of the transform block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_dft_time_series_assert.svh"

module cdft_checker #(
  parameter int SERIES_LENGTH = 64
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_ready_i,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire signed [37:0] out_real_i,
  input wire signed [37:0] out_imag_i,
  input wire        [5:0]  out_bin_i,
  input wire signed [5:0]  out_mom_i,
  input wire               out_last_i
);

  import cdft_pkg::*;

  localparam int HALF = SERIES_LENGTH / 2;

  logic [BIN_W-1:0] mom_exp;
  logic             out_fire;

  // Expected momentum folds the upper half of the bins below zero.
  assign mom_exp  = (out_bin_i < BIN_W'(HALF)) ? out_bin_i :
                    BIN_W'(7'(out_bin_i) - 7'(SERIES_LENGTH));
  assign out_fire = out_valid_i && out_ready_i;

  // A held bin beat keeps its spectrum, bin number and end mark.
  `CDFT_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_real_i) && $stable(out_imag_i) && $stable(out_bin_i) && $stable(out_last_i))

  // The end mark comes only with the final bin.
  `CDFT_ASSERT(a_last_bin, out_valid_i && out_last_i |-> out_bin_i == BIN_W'(SERIES_LENGTH - 1))

  // Momentum agrees with the bin number.
  `CDFT_ASSERT(a_momentum, out_valid_i |-> out_mom_i == $signed(mom_exp))

  // No sample is taken while a bin before the last of the run is handed over.
  `CDFT_ASSERT(a_no_load_mid_run, out_fire && !out_last_i |-> !in_ready_i)

  // Reset clears the output side.
  `CDFT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_i)

endmodule

bind complex_dft_time_series cdft_checker #(
  .SERIES_LENGTH(SERIES_LENGTH)
) u_cdft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (bin_o.valid),
  .out_ready_i (bin_o.ready),
  .out_real_i  (bin_o.spectrum_real),
  .out_imag_i  (bin_o.spectrum_imag),
  .out_bin_i   (bin_o.bin_index),
  .out_mom_i   (bin_o.signed_momentum),
  .out_last_i  (bin_o.last_of_run)
);

`default_nettype wire

// ===== tb/tb_complex_dft_time_series.sv =====
// ----------------------------------------------------------------------------
// tb_complex_dft_time_series
// Self-checking bench for the direct complex DFT block. Sample beats are
// driven on the input channel while a predictor keeps its own copy of the
// series and its own twiddle table. Each completed series queues one
// expected bin beat per frequency, and every bin beat that leaves the block
// is compared with the oldest one. A full-scale series pushes bin one into
// positive saturation, a random series loads under sender gaps and drains
// under receiver stalls, and a last full-scale series, sent with both sides
// idling, pushes bin one into negative saturation.
// ----------------------------------------------------------------------------

module tb_complex_dft_time_series;
  import cdft_pkg::*;

  localparam int SERIES_N     = 64;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  // Allow quiet time for two bins, plus margin.
  localparam int DRAIN_CYCLES = 2 * (SERIES_N + 4) + 20;

  localparam longint Q30_ONE        = 64'sd1073741824;
  localparam longint Q30_QUARTER_PI = 64'sd843314857;
  localparam longint ROUND_BIAS     = 64'sd131072;
  localparam longint SPECTRUM_MAX   = (64'sd1 <<< 37) - 64'sd1;
  localparam longint SPECTRUM_MIN   = -(64'sd1 <<< 37);

  localparam logic signed [SMP_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SMP_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [SMP_W-1:0] SAMPLE_ONE = 32'sh0001_0000;

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic        [BIN_W-1:0] bin_no;
    logic signed [BIN_W-1:0] momentum;
    logic                    last;
  } bin_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cdft_sample_if sample_if ();
  cdft_bin_if    bin_if ();

  complex_dft_time_series #(
    .SERIES_LENGTH(SERIES_N)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sample_i(sample_if),
    .bin_o (bin_if)
  );

  // Twiddle table and the loaded series as the predictor sees them.
  longint                  twiddle_cos [SERIES_N];
  longint                  twiddle_sin [SERIES_N];
  logic signed [SMP_W-1:0] series_re [SERIES_N];
  logic signed [SMP_W-1:0] series_im [SERIES_N];
  int                      fill_count = 0;
  bin_beat_t               pending_bins [$];

  int          send_idle_pct = 0;
  int          bin_stall_pct = 0;
  bit          failed        = 1'b0;
  int unsigned cycle_count   = 0;

  always begin
    #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // Cosine and sine of a first-octant angle in Q30, rounded to Q1.18.
  function automatic void octant_cos_sin(input longint theta, output longint c18,
                                         output longint s18);
    longint x2;
    longint cterm;
    longint sterm;
    longint c;
    longint s;
    x2    = (theta * theta) >>> 30;
    cterm = Q30_ONE;
    c     = Q30_ONE;
    sterm = theta;
    s     = theta;
    for (int n = 1; n <= 7; n++) begin
      cterm = ((cterm * x2) >>> 30) / ((2 * n - 1) * (2 * n));
      sterm = ((sterm * x2) >>> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        c = c - cterm;
        s = s - sterm;
      end else begin
        c = c + cterm;
        s = s + sterm;
      end
    end
    if (c < 0) begin
      c = 0;
    end
    if (s < 0) begin
      s = 0;
    end
    c18 = (c + 2048) >>> 12;
    s18 = (s + 2048) >>> 12;
  endfunction

  // Fill the table for angles 2*pi*m/N by folding each one into the first octant.
  function automatic void build_twiddles();
    int     octant;
    int     offset;
    int     part;
    longint theta;
    longint c;
    longint s;
    for (int m = 0; m < SERIES_N; m++) begin
      octant = (8 * m) / SERIES_N;
      offset = (8 * m) % SERIES_N;
      part   = (octant % 2 == 1) ? SERIES_N - offset : offset;
      theta  = (longint'(part) * Q30_QUARTER_PI + SERIES_N / 2) / SERIES_N;
      octant_cos_sin(theta, c, s);
      case (octant % 8)
        0: begin twiddle_cos[m] = c;  twiddle_sin[m] = s;  end
        1: begin twiddle_cos[m] = s;  twiddle_sin[m] = c;  end
        2: begin twiddle_cos[m] = -s; twiddle_sin[m] = c;  end
        3: begin twiddle_cos[m] = -c; twiddle_sin[m] = s;  end
        4: begin twiddle_cos[m] = -c; twiddle_sin[m] = -s; end
        5: begin twiddle_cos[m] = -s; twiddle_sin[m] = -c; end
        6: begin twiddle_cos[m] = s;  twiddle_sin[m] = -c; end
        default: begin twiddle_cos[m] = c; twiddle_sin[m] = -s; end
      endcase
    end
  endfunction

  // Round a Q30.34 sum to Q22.16 (half up) and clamp it to the output range.
  function automatic logic signed [OUT_W-1:0] round_to_output(input longint acc);
    longint r;
    r = (acc + ROUND_BIAS) >>> 18;
    if (r > SPECTRUM_MAX) begin
      r = SPECTRUM_MAX;
    end
    if (r < SPECTRUM_MIN) begin
      r = SPECTRUM_MIN;
    end
    return OUT_W'(r);
  endfunction

  // Store one sample; the last sample of a series queues the whole spectrum.
  function automatic void load_sample(input logic signed [SMP_W-1:0] re,
                                      input logic signed [SMP_W-1:0] im);
    longint    acc_re;
    longint    acc_im;
    longint    xr;
    longint    xi;
    int        m;
    bin_beat_t beat;
    series_re[fill_count] = re;
    series_im[fill_count] = im;
    fill_count++;
    if (fill_count == SERIES_N) begin
      fill_count = 0;
      for (int k = 0; k < SERIES_N; k++) begin
        acc_re = 0;
        acc_im = 0;
        for (int t = 0; t < SERIES_N; t++) begin
          xr     = series_re[t];
          xi     = series_im[t];
          m      = (k * t) % SERIES_N;
          acc_re = acc_re + xr * twiddle_cos[m] + xi * twiddle_sin[m];
          acc_im = acc_im + xi * twiddle_cos[m] - xr * twiddle_sin[m];
        end
        beat.re       = round_to_output(acc_re);
        beat.im       = round_to_output(acc_im);
        beat.bin_no   = BIN_W'(k);
        beat.momentum = (k + 1 > SERIES_N / 2) ? BIN_W'(k - SERIES_N) : BIN_W'(k);
        beat.last     = (k == SERIES_N - 1);
        pending_bins.push_back(beat);
      end
    end
  endfunction

  task automatic check_field(input string field, input int bin_no,
                             input logic signed [63:0] want, input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: bin %0d %s expected %0d, got %0d", $time, bin_no, field, want, got);
      failed = 1'b1;
    end
  endtask

  // Run timeout.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every accepted sample beat goes to the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      load_sample(sample_if.sample_real, sample_if.sample_imag);
    end
  end

  // Every accepted bin beat is checked against the oldest expected one.
  always @(posedge clk_i) begin : check_bins
    bin_beat_t want;
    if (rst_ni && bin_if.valid && bin_if.ready) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected bin beat, bin %0d real %0d imag %0d", $time,
                 bin_if.bin_index, bin_if.spectrum_real, bin_if.spectrum_imag);
        failed = 1'b1;
      end else begin
        want = pending_bins.pop_front();
        check_field("spectrum_real", want.bin_no, want.re, bin_if.spectrum_real);
        check_field("spectrum_imag", want.bin_no, want.im, bin_if.spectrum_imag);
        check_field("bin_index", want.bin_no, want.bin_no, bin_if.bin_index);
        check_field("signed_momentum", want.bin_no, want.momentum, bin_if.signed_momentum);
        check_field("last_of_run", want.bin_no, want.last, bin_if.last_of_run);
      end
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    bin_if.ready <= ($urandom_range(99) >= bin_stall_pct);
  end

  // Send one sample beat. Called and returns at a falling edge; valid stays
  // high on return so that back-to-back beats need no extra edge.
  task automatic send_sample(input logic signed [SMP_W-1:0] re,
                             input logic signed [SMP_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid       <= 1'b0;
      sample_if.sample_real <= $urandom;
      sample_if.sample_imag <= $urandom;
      @(negedge clk_i);
    end
    sample_if.valid       <= 1'b1;
    sample_if.sample_real <= re;
    sample_if.sample_imag <= im;
    do begin
      @(posedge clk_i);
    end while (!sample_if.ready);
    @(negedge clk_i);
  endtask

  // Hold the sender back until every queued bin has come out.
  task automatic wait_for_bins();
    sample_if.valid <= 1'b0;
    while (pending_bins.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Full-range values half of the time, with small values, corner values and zeros mixed in.
  function automatic logic signed [SMP_W-1:0] random_part();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return $urandom;
    end
    if (pick < 70) begin
      return SMP_W'($signed($urandom_range(131071)) - 65536);
    end
    if (pick < 85) begin
      case ($urandom_range(4))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return -1;
        3: return SAMPLE_ONE;
        default: return '0;
      endcase
    end
    return '0;
  endfunction

  task automatic send_random_series();
    for (int t = 0; t < SERIES_N; t++) begin
      send_sample(random_part(), random_part());
    end
  endtask

  // Full-scale samples whose signs follow the bin one twiddle, so that the
  // real sum of bin one overflows upward, or downward with the signs flipped.
  task automatic send_saturating_series(input logic upward);
    for (int t = 0; t < SERIES_N; t++) begin
      send_sample(((twiddle_cos[t] >= 0) == upward) ? SAMPLE_MAX : SAMPLE_MIN,
                  ((twiddle_sin[t] >= 0) == upward) ? SAMPLE_MAX : SAMPLE_MIN);
    end
  endtask

  // Bin one clamps at the top with neither side idle. The next series is
  // offered at once, so it waits on this spectrum.
  task automatic test_saturation_high();
    send_idle_pct = 0;
    bin_stall_pct = 0;
    send_saturating_series(1'b1);
  endtask

  // The sender idles often while a random series loads.
  task automatic test_sender_gaps();
    send_idle_pct = 81;
    bin_stall_pct = 0;
    send_random_series();
  endtask

  // The spectrum of that series leaves under heavy receiver stalls while the
  // sender holds back until every bin is out.
  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    bin_stall_pct = 81;
    wait_for_bins();
  endtask

  // Bin one clamps at the bottom with both sides idling now and then.
  task automatic test_both_idle();
    send_idle_pct = 31;
    bin_stall_pct = 31;
    send_saturating_series(1'b0);
    wait_for_bins();
  endtask

  initial begin
    sample_if.valid       = 1'b0;
    sample_if.sample_real = '0;
    sample_if.sample_imag = '0;
    bin_if.ready          = 1'b0;
    build_twiddles();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_saturation_high();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    // Quiet period with the receiver always ready: nothing more may come out.
    bin_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (!failed && pending_bins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
